// ----- sv/abp_pkg.sv -----
// Shared types, constants and helper functions for the ASCII P1 bitmap parser.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

    // Dimension accumulators are DIM_BITS wide, the pixel counters twice that.
    localparam int DIM_BITS   = 12;
    localparam int TOTAL_BITS = 2 * DIM_BITS;
    localparam int ACC_BITS   = DIM_BITS + 4;
    localparam logic [ACC_BITS-1:0] DIM_MAX = ACC_BITS'((1 << DIM_BITS) - 1);

    // Fixed field widths of the result item.
    localparam int PIX_W = 8;
    localparam int IDX_W = 24;
    localparam int DIMO_W = 12;
    localparam int STAT_W = 3;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] SHORT_LEN = 4'd8;
    localparam logic [CNT_W-1:0] HDR_LEN   = 4'd3;
    localparam logic [CNT_W-1:0] HDR_LAST  = 4'd2;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = PTR_W + 1;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_HEADER  = 3'd2,
        ST_BADCHAR = 3'd3,
        ST_TOOMANY = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_MISSING = 3'd6,
        ST_DIMOVF  = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_WIDTH  = 4'b0010,
        PH_HEIGHT = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  pixel_value;
        logic [IDX_W-1:0]  pixel_index;
        logic [DIMO_W-1:0] image_width;
        logic [DIMO_W-1:0] image_height;
        logic [STAT_W-1:0] status;
        logic              last;
    } out_item_t;

    typedef struct packed {
        phase_t                phase;
        logic [CNT_W-1:0]      byte_count;
        logic                  in_comment;
        logic                  in_number;
        logic [DIM_BITS-1:0]   width_acc;
        logic [DIM_BITS-1:0]   height_acc;
        logic [TOTAL_BITS-1:0] pixel_total;
        logic [TOTAL_BITS-1:0] pixels_seen;
        status_t               first_error;
    } parse_state_t;

    // What one byte produces: an optional pixel and an optional summary.
    typedef struct packed {
        logic      emit_pixel;
        logic      emit_summary;
        out_item_t pixel;
        out_item_t summary;
    } step_out_t;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_HEADER,
        byte_count:  '0,
        in_comment:  1'b0,
        in_number:   1'b0,
        width_acc:   '0,
        height_acc:  '0,
        pixel_total: '0,
        pixels_seen: '0,
        first_error: ST_OK
    };

    function automatic logic [7:0] header_char(input logic [1:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                2'd0:    ch = CH_P;
                2'd1:    ch = CH_ONE;
                2'd2:    ch = CH_NL;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ----- sv/abp_step.sv -----
// Combinational parse step: next parser state and the results of one byte.
// Depends on abp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abp_step
    import abp_pkg::*;
(
    input  parse_state_t state,
    input  in_item_t     item,
    output parse_state_t state_next,
    output step_out_t    result
);

    logic [7:0]            c;
    logic                  digit;
    logic [DIM_BITS-1:0]   acc;
    logic [ACC_BITS-1:0]   acc_x10;
    logic [TOTAL_BITS-1:0] product;
    parse_state_t          s;
    logic                  done;
    logic                  entered;
    status_t               st_code;

    assign c       = item.char_byte;
    assign digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc     = (state.phase == PH_WIDTH) ? state.width_acc : state.height_acc;
    assign acc_x10 = ACC_BITS'({acc, 3'b000}) + ACC_BITS'({acc, 1'b0})
                   + ACC_BITS'(c[3:0]);
    assign product = TOTAL_BITS'(state.width_acc) * TOTAL_BITS'(state.height_acc);

    always_comb
    begin
        s       = state;
        result  = '0;
        done    = 1'b0;
        entered = 1'b0;
        st_code = ST_OK;

        if (state.byte_count < SHORT_LEN)
        begin
            s.byte_count = state.byte_count + 4'd1;
        end

        if (state.first_error == ST_OK)
        begin
            if (state.phase == PH_HEADER)
            begin
                if ((state.byte_count >= HDR_LEN)
                    || (c != header_char(state.byte_count[1:0])))
                begin
                    s.first_error = ST_HEADER;
                end
                else if (state.byte_count == HDR_LAST)
                begin
                    s.phase = PH_WIDTH;
                end
            end
            else
            begin
                // A non-digit ends the number and is then handled as usual.
                if (state.in_number)
                begin
                    if (digit)
                    begin
                        done = 1'b1;
                        if (acc_x10 > DIM_MAX)
                        begin
                            s.first_error = ST_DIMOVF;
                        end
                        else if (state.phase == PH_WIDTH)
                        begin
                            s.width_acc = acc_x10[DIM_BITS-1:0];
                        end
                        else
                        begin
                            s.height_acc = acc_x10[DIM_BITS-1:0];
                        end
                    end
                    else
                    begin
                        s.in_number = 1'b0;
                        if (state.phase == PH_WIDTH)
                        begin
                            s.phase = PH_HEIGHT;
                        end
                        else if (state.phase == PH_HEIGHT)
                        begin
                            s.pixel_total = product;
                            if ((state.width_acc == '0) || (state.height_acc == '0))
                            begin
                                s.first_error = ST_EMPTY;
                            end
                            else
                            begin
                                s.phase = PH_DATA;
                                entered = 1'b1;
                            end
                        end
                    end
                end

                if (!done && (s.first_error == ST_OK))
                begin
                    priority if (state.in_comment)
                    begin
                        if (c == CH_NL)
                        begin
                            s.in_comment = 1'b0;
                        end
                    end
                    else if (c == CH_HASH)
                    begin
                        s.in_comment = 1'b1;
                    end
                    else if (!is_space(c))
                    begin
                        if ((s.phase == PH_WIDTH) || (s.phase == PH_HEIGHT))
                        begin
                            if (digit)
                            begin
                                s.in_number = 1'b1;
                                if (acc_x10 > DIM_MAX)
                                begin
                                    s.first_error = ST_DIMOVF;
                                end
                                else if (state.phase == PH_WIDTH)
                                begin
                                    s.width_acc = acc_x10[DIM_BITS-1:0];
                                end
                                else
                                begin
                                    s.height_acc = acc_x10[DIM_BITS-1:0];
                                end
                            end
                            else
                            begin
                                s.first_error = ST_EMPTY;
                            end
                        end
                        else if ((c == CH_ZERO) || (c == CH_ONE))
                        begin
                            // Data can only just have been entered on a byte that is
                            // not a pixel, so the stored total is current here.
                            if (state.pixels_seen >= state.pixel_total)
                            begin
                                s.first_error = ST_TOOMANY;
                            end
                            else
                            begin
                                result.emit_pixel        = 1'b1;
                                result.pixel.kind        = KIND_PIXEL;
                                result.pixel.pixel_value = (c == CH_ZERO) ? PIX_WHITE
                                                                          : PIX_BLACK;
                                result.pixel.pixel_index = IDX_W'(state.pixels_seen);
                                s.pixels_seen = state.pixels_seen + TOTAL_BITS'(1);
                            end
                        end
                        else
                        begin
                            s.first_error = ST_BADCHAR;
                        end
                    end
                    else
                    begin
                        // Whitespace only separates tokens.
                    end
                end
            end
        end

        if (item.end_of_file)
        begin
            // A number still open at the end is closed as if a separator came.
            if ((s.first_error == ST_OK) && s.in_number)
            begin
                s.in_number = 1'b0;
                if (s.phase == PH_WIDTH)
                begin
                    s.phase = PH_HEIGHT;
                end
                else if (s.phase == PH_HEIGHT)
                begin
                    if ((s.width_acc == '0) || (s.height_acc == '0))
                    begin
                        s.first_error = ST_EMPTY;
                    end
                    else
                    begin
                        s.phase = PH_DATA;
                        entered = 1'b1;
                    end
                end
            end

            // Data that was only just entered cannot hold any pixel yet.
            priority if (s.byte_count < SHORT_LEN)
            begin
                st_code = ST_SHORT;
            end
            else if (s.first_error != ST_OK)
            begin
                st_code = s.first_error;
            end
            else if (s.phase != PH_DATA)
            begin
                st_code = ST_EMPTY;
            end
            else if (entered || (s.pixels_seen != s.pixel_total))
            begin
                st_code = ST_MISSING;
            end
            else
            begin
                st_code = ST_OK;
            end

            result.emit_summary         = 1'b1;
            result.summary.kind         = KIND_SUMMARY;
            result.summary.pixel_value  = '0;
            result.summary.pixel_index  = IDX_W'(s.pixels_seen);
            result.summary.image_width  = DIMO_W'(s.width_acc);
            result.summary.image_height = DIMO_W'(s.height_acc);
            result.summary.status       = st_code;
            result.summary.last         = 1'b1;
        end

        state_next = item.end_of_file ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

// ----- sv/abp_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on abp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abp_out_fifo
    import abp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_0,
    input  out_item_t data_0,
    input  logic      push_1,
    input  out_item_t data_1,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [FCNT_W-1:0]      count_reg;
    logic [FCNT_W-1:0]      count_next;
    logic                   pop;
    logic [1:0]             push_n;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for the worst case of one byte: a pixel and a summary.
    assign room      = (count_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign push_n    = {1'b0, push_0} + {1'b0, push_1};

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + FCNT_W'(push_n) - FCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_0)
        begin
            mem[wr_ptr_reg] <= data_0;
        end
        if (push_1)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= data_1;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ascii_bitmap_p1_parser.sv -----
// Top level of the ASCII P1 bitmap parser: input register, parse step, result queue.
// Depends on abp_pkg, abp_step and abp_out_fifo.
//
// Usage: bytes of a plain P1 bitmap enter on in_item (char_byte, end_of_file)
// with in_valid/in_ready; each transfer is one byte. Results leave on out_item
// with out_valid/out_ready: one pixel result per '0' or '1' pixel character,
// and after the byte marked end_of_file one summary result (kind 1, last 1)
// with width, height, pixel count and status. The parser then starts over.
// A byte is held in the input register and its results are written into the
// result queue, which offers them; a summary follows a pixel of the same byte.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// yields a pixel and a summary fills two queue entries. The four-entry result
// queue sets this: a byte leaves the input register only when two entries
// are free.
// Reset clears the parser state, the input register and the queue.
// When the receiver stalls, results wait in the queue; once fewer than two
// entries are free the input register holds its byte and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module ascii_bitmap_p1_parser
    import abp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    step_out_t    step;
    logic         room;
    logic         fire;
    logic         push_0;
    logic         push_1;
    out_item_t    data_0;

    abp_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step)
    );

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;

    assign push_0 = fire && (step.emit_pixel || step.emit_summary);
    assign push_1 = fire && step.emit_pixel && step.emit_summary;
    assign data_0 = step.emit_pixel ? step.pixel : step.summary;

    abp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_0    (push_0),
        .data_0    (data_0),
        .push_1    (push_1),
        .data_1    (step.summary),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

`ifndef SYNTHESIS
    // Once an error is recorded, no further pixel may be produced.
    a_no_pixel_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (state_reg.first_error != ST_OK)) |-> !step.emit_pixel)
        else $error("pixel produced after an error");

    // The end of a file returns the parser to its initial state.
    a_restart_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.end_of_file) |=>
            ((state_reg.phase == PH_HEADER) && (state_reg.byte_count == '0)
             && (state_reg.first_error == ST_OK)))
        else $error("parser did not restart after end of file");

    // A byte held in the input register is released only when the queue has room.
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input byte lost while the result queue was full");
`endif

endmodule

`default_nettype wire
